// File: rtl/t2_decay_model_eval_macros.svh
// Assertion macros shared by the decay model evaluator.
`ifndef T2_DECAY_MODEL_EVAL_MACROS_SVH
`define T2_DECAY_MODEL_EVAL_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define T2DM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define T2DM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/t2dm_pkg.sv
package t2dm_pkg;

  // Field widths
  localparam int DENS_W  = 32;
  localparam int T2_W    = 24;
  localparam int ECHO_W  = 24;
  localparam int VOL_W   = 8;
  localparam int SCALE_W = 16;
  localparam int VAL_W   = 32;

  // Ratio echo/T2 in Q4.16, only the range below 16.0 is kept
  localparam int FRAC_W = 16;
  localparam int INT_W  = 4;
  localparam int XQ_W   = INT_W + FRAC_W;
  localparam int NUM_W  = ECHO_W + FRAC_W + 1;
  localparam int CMP_W  = T2_W + XQ_W;

  // Exponential tables and products
  localparam int INT_LIMIT         = 16;
  localparam int INT_TAB_W         = 32;
  localparam int FRAC_TAB_W        = 17;
  localparam int EQ_W              = 17;
  localparam int SE_W              = 32;
  localparam int PROD_W            = 64;
  localparam int ROUND_SHIFT       = 30;
  localparam int SERIES_TERMS      = 24;
  localparam int EXP_TABLE_DEPTH_DEF = 256;

  localparam logic [SCALE_W-1:0] UNIT_SCALE = 16'd16384;

  typedef struct packed {
    logic [DENS_W-1:0]  proton_density;
    logic [T2_W-1:0]    t2_time;
    logic [ECHO_W-1:0]  echo_time;
    logic [VOL_W-1:0]   volume_index;
    logic [SCALE_W-1:0] volume_scale;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] model_value;
    logic             zero_t2;
  } out_t;

  // Item data that rides alongside the ratio and exponential pipelines
  typedef struct packed {
    logic [DENS_W-1:0]  density;
    logic [SCALE_W-1:0] scale;
    logic               zero_t2;
  } side_t;

endpackage

// File: rtl/t2_decay_model_eval.sv
// Mono-exponential T2 decay model: each transfer in gives one transfer out carrying
// scale * proton_density * exp(-echo_time / t2_time), rounded half up and saturated
// to 32 bits; volume 0 uses a scale of 1.0, and a zero T2 gives 0 with zero_t2 set.
// The block takes one item every cycle while in_stall is low and holds up to 29 items
// in flight, most of them in the ratio divider, which settles one quotient bit per
// stage over 20 stages after a range check. out_stall freezes the whole pipeline,
// so in_stall rises only while a finished result sits in the output register and
// is itself stalled.
module t2_decay_model_eval #(
  parameter int EXP_TABLE_DEPTH = t2dm_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  t2dm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output t2dm_pkg::out_t out_data
);
  import t2dm_pkg::*;

  logic adv;
  logic out_valid_r;

  // Move every stage unless the output holds a stalled transfer
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Stage A: numerator with half divisor for rounding, scale select
  logic             a_vld_r;
  logic [NUM_W-1:0] a_num_r;
  logic [T2_W-1:0]  a_den_r;
  side_t            a_side_r;

  logic [NUM_W-1:0]   num_nxt;
  logic [SCALE_W-1:0] scale_nxt;
  side_t              side_nxt;

  assign num_nxt   = {1'b0, in_data.echo_time, {FRAC_W{1'b0}}}
                   + NUM_W'(in_data.t2_time >> 1);
  assign scale_nxt = (in_data.volume_index == '0) ? UNIT_SCALE : in_data.volume_scale;
  assign side_nxt  = '{density: in_data.proton_density,
                       scale:   scale_nxt,
                       zero_t2: (in_data.t2_time == '0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_num_r  <= num_nxt;
      a_den_r  <= in_data.t2_time;
      a_side_r <= side_nxt;
    end
  end

  // Ratio echo/T2 in Q4.16
  logic            div_vld;
  logic            div_over;
  logic [XQ_W-1:0] div_quo;
  side_t           div_side;

  t2dm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (a_vld_r),
    .in_num   (a_num_r),
    .in_den   (a_den_r),
    .in_side  (a_side_r),
    .out_vld  (div_vld),
    .out_over (div_over),
    .out_quo  (div_quo),
    .out_side (div_side)
  );

  // exp(-ratio) in Q0.16
  logic            exp_vld;
  logic [EQ_W-1:0] exp_eq;
  side_t           exp_side;

  t2dm_exp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (div_vld),
    .in_over  (div_over),
    .in_xq    (div_quo),
    .in_side  (div_side),
    .out_vld  (exp_vld),
    .out_eq   (exp_eq),
    .out_side (exp_side)
  );

  // Stage M2: exponential times scale
  logic [EQ_W+SCALE_W-1:0] se_full;

  assign se_full = {{SCALE_W{1'b0}}, exp_eq} * {{EQ_W{1'b0}}, exp_side.scale};

  logic              m2_vld_r;
  logic [SE_W-1:0]   m2_se_r;
  logic [DENS_W-1:0] m2_dens_r;
  logic              m2_zero_r;

  // Stage M3: times density
  logic              m3_vld_r;
  logic [PROD_W-1:0] m3_prod_r;
  logic              m3_zero_r;

  // Output: round off Q2.14 and Q0.16 fractions, saturate
  localparam int SC_W = PROD_W - ROUND_SHIFT + 1;

  logic [PROD_W:0]   rnd;
  logic [SC_W-1:0]   scaled;
  logic [VAL_W-1:0]  val_nxt;
  out_t              out_data_r;

  assign rnd     = {1'b0, m3_prod_r} + ((PROD_W+1)'(1) << (ROUND_SHIFT - 1));
  assign scaled  = rnd[PROD_W:ROUND_SHIFT];
  assign val_nxt = m3_zero_r                  ? '0 :
                   (|scaled[SC_W-1:VAL_W])    ? '1 : scaled[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r    <= 1'b0;
      m3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m2_vld_r    <= exp_vld;
      m3_vld_r    <= m2_vld_r;
      out_valid_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_se_r    <= se_full[SE_W-1:0];
      m2_dens_r  <= exp_side.density;
      m2_zero_r  <= exp_side.zero_t2;

      m3_prod_r  <= {{(PROD_W-DENS_W){1'b0}}, m2_dens_r} * {{(PROD_W-SE_W){1'b0}}, m2_se_r};
      m3_zero_r  <= m2_zero_r;

      out_data_r <= '{model_value: val_nxt, zero_t2: m3_zero_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the datapath
`include "t2_decay_model_eval_macros.svh"

  `T2DM_ASSERT_IMPL(a_zero_t2_over, clk, rst_n, div_vld && div_side.zero_t2, div_over, "zero T2 not flagged as out of range")
  `T2DM_ASSERT_IMPL(a_eq_bound, clk, rst_n, exp_vld, exp_eq <= 17'd65536, "exponential above 1.0")
  `T2DM_ASSERT_IMPL(a_zero_t2_val, clk, rst_n, out_valid_r && out_data_r.zero_t2, out_data_r.model_value == '0, "zero T2 with nonzero value")
  `T2DM_ASSERT_NEXT(a_out_follow, clk, rst_n, adv, out_valid_r == $past(m3_vld_r), "output valid lost or invented")

endmodule

// File: rtl/t2dm_div.sv
module t2dm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [t2dm_pkg::NUM_W-1:0]  in_num,
  input  logic [t2dm_pkg::T2_W-1:0]   in_den,
  input  t2dm_pkg::side_t             in_side,
  output logic                        out_vld,
  output logic                        out_over,
  output logic [t2dm_pkg::XQ_W-1:0]   out_quo,
  output t2dm_pkg::side_t             out_side
);
  import t2dm_pkg::*;

  // Range check stage, then one quotient bit per stage, MSB first
  localparam int NSTG = XQ_W;

  logic             vld_r  [0:NSTG];
  logic             over_r [0:NSTG];
  side_t            side_r [0:NSTG];
  logic [XQ_W-1:0]  quo_r  [0:NSTG];
  logic [NUM_W-1:0] rem_r  [0:NSTG-1];
  logic [T2_W-1:0]  den_r  [0:NSTG-1];

  logic [CMP_W-1:0] lim;
  logic             over_nxt;

  // Flag ratios of 16.0 or more; a zero T2 always lands here
  assign lim      = {{(CMP_W-T2_W){1'b0}}, in_den} << XQ_W;
  assign over_nxt = {{(CMP_W-NUM_W){1'b0}}, in_num} >= lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      over_r[0] <= over_nxt;
      side_r[0] <= in_side;
      quo_r[0]  <= '0;
      rem_r[0]  <= in_num;
      den_r[0]  <= in_den;
    end
  end

  for (genvar s = 1; s <= NSTG; s++) begin : g_stg
    localparam int B = NSTG - s;

    logic [CMP_W-1:0] shd;
    logic             ge;

    // Trial subtract of the shifted divisor
    assign shd = {{(CMP_W-T2_W){1'b0}}, den_r[s-1]} << B;
    assign ge  = {{(CMP_W-NUM_W){1'b0}}, rem_r[s-1]} >= shd;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        over_r[s] <= over_r[s-1];
        side_r[s] <= side_r[s-1];
        quo_r[s]  <= quo_r[s-1] | (XQ_W'(ge) << B);
      end
    end

    if (s < NSTG) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[s] <= ge ? (rem_r[s-1] - shd[NUM_W-1:0]) : rem_r[s-1];
          den_r[s] <= den_r[s-1];
        end
      end
    end
  end

  assign out_vld  = vld_r[NSTG];
  assign out_over = over_r[NSTG];
  assign out_quo  = quo_r[NSTG];
  assign out_side = side_r[NSTG];

endmodule

// File: rtl/t2dm_exp.sv
module t2dm_exp #(
  parameter int EXP_TABLE_DEPTH = t2dm_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  logic                       in_over,
  input  logic [t2dm_pkg::XQ_W-1:0]  in_xq,
  input  t2dm_pkg::side_t            in_side,
  output logic                       out_vld,
  output logic [t2dm_pkg::EQ_W-1:0]  out_eq,
  output t2dm_pkg::side_t            out_side
);
  import t2dm_pkg::*;

  localparam int JW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PW  = FRAC_W + JW + 1;
  localparam int JRW = PW - FRAC_W;
  localparam int P_W = INT_TAB_W + FRAC_TAB_W;

  localparam logic [PW-1:0]  DEPTH_P = PW'(EXP_TABLE_DEPTH);
  localparam logic [PW-1:0]  HALF_P  = PW'(1) << (FRAC_W - 1);
  localparam logic [P_W:0]   RND_EQ  = (P_W+1)'(1) << (INT_TAB_W - 2);

  // Quotient of two elaboration-time values by shift and subtract
  function automatic logic [63:0] quo64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-k/D) in Q48 by the alternating Taylor series, truncating each term
  function automatic logic [63:0] series_q48(input int unsigned k);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    int          n;
    term = 64'd1 << 48;
    pos  = term;
    neg  = '0;
    for (n = 1; n <= SERIES_TERMS; n++) begin
      term = quo64(term * 64'(k), 64'(EXP_TABLE_DEPTH) * 64'(n));
      if (n[0]) neg = neg + term;
      else      pos = pos + term;
    end
    return (pos >= neg) ? (pos - neg) : 64'd0;
  endfunction

  // Fraction table entry, Q0.16 with 1.0 held as 65536
  function automatic logic [FRAC_TAB_W-1:0] frac_val(input int unsigned k);
    logic [63:0] v;
    v = (series_q48(k) + (64'd1 << 31)) >> 32;
    return v[FRAC_TAB_W-1:0];
  endfunction

  // Integer table entry exp(-i) in Q1.31, chained from exp(-1)
  function automatic logic [INT_TAB_W-1:0] int_val(input int unsigned i);
    logic [63:0] e1;
    logic [63:0] v;
    int unsigned m;
    e1 = (series_q48(EXP_TABLE_DEPTH) + (64'd1 << 16)) >> 17;
    v  = 64'd1 << 31;
    for (m = 1; m <= i; m++) begin
      v = (v * e1 + (64'd1 << 30)) >> 31;
    end
    return v[INT_TAB_W-1:0];
  endfunction

  logic [FRAC_TAB_W-1:0] frac_rom [0:EXP_TABLE_DEPTH];
  logic [INT_TAB_W-1:0]  int_rom  [0:INT_LIMIT-1];

  for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_frac
    localparam logic [FRAC_TAB_W-1:0] FV = frac_val(g);
    assign frac_rom[g] = FV;
  end

  for (genvar g = 0; g < INT_LIMIT; g++) begin : g_int
    localparam logic [INT_TAB_W-1:0] IV = int_val(g);
    assign int_rom[g] = IV;
  end

  // Stage L: split the ratio, round the fraction to a table index
  logic [PW-1:0]  jprod;
  logic [JRW-1:0] jraw;
  logic [JW-1:0]  j_nxt;

  assign jprod = PW'(in_xq[FRAC_W-1:0]) * DEPTH_P + HALF_P;
  assign jraw  = jprod[PW-1:FRAC_W];
  assign j_nxt = (jraw > JRW'(EXP_TABLE_DEPTH)) ? JW'(EXP_TABLE_DEPTH) : jraw[JW-1:0];

  logic             l_vld_r;
  logic             l_over_r;
  side_t            l_side_r;
  logic [JW-1:0]    l_j_r;
  logic [INT_W-1:0] l_i_r;

  // Stage R: table reads
  logic                  r_vld_r;
  logic                  r_over_r;
  side_t                 r_side_r;
  logic [FRAC_TAB_W-1:0] r_frac_r;
  logic [INT_TAB_W-1:0]  r_int_r;

  // Stage P: table product
  logic           p_vld_r;
  logic           p_over_r;
  side_t          p_side_r;
  logic [P_W-1:0] p_prod_r;

  // Stage E: rounded Q0.16 exponential
  logic            e_vld_r;
  side_t           e_side_r;
  logic [EQ_W-1:0] e_eq_r;

  logic [P_W:0]    rnd;
  logic [EQ_W-1:0] eq_nxt;

  assign rnd    = {1'b0, p_prod_r} + RND_EQ;
  assign eq_nxt = p_over_r ? '0 : rnd[INT_TAB_W-1+EQ_W-1:INT_TAB_W-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else if (adv) begin
      l_vld_r <= in_vld;
      r_vld_r <= l_vld_r;
      p_vld_r <= r_vld_r;
      e_vld_r <= p_vld_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      l_over_r <= in_over;
      l_side_r <= in_side;
      l_j_r    <= j_nxt;
      l_i_r    <= in_xq[XQ_W-1:FRAC_W];

      r_over_r <= l_over_r;
      r_side_r <= l_side_r;
      r_frac_r <= frac_rom[l_j_r];
      r_int_r  <= int_rom[l_i_r];

      p_over_r <= r_over_r;
      p_side_r <= r_side_r;
      p_prod_r <= P_W'(r_int_r) * P_W'(r_frac_r);

      e_side_r <= p_side_r;
      e_eq_r   <= eq_nxt;
    end
  end

  assign out_vld  = e_vld_r;
  assign out_eq   = e_eq_r;
  assign out_side = e_side_r;

endmodule

// File: test/t2dm_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the decay model evaluator, predicts each result from the
// accepted item and compares it with the oldest prediction still waiting.
module t2dm_checker #(
  parameter int DEPTH = t2dm_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  t2dm_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  t2dm_pkg::out_t out_data,
  output int             mismatches,
  output int             awaited
);

  import t2dm_pkg::*;

  // exp(-k/DEPTH) in Q0.16 (1.0 as 65536) and exp(-i) in Q1.31
  logic [16:0] frac_lut [0:DEPTH];
  logic [63:0] whole_lut [0:INT_LIMIT-1];

  out_t pending_values [$];
  out_t want;
  int   step_errs;

  // exp(-k/DEPTH) in Q48 by an alternating Taylor sum with truncated terms
  function automatic logic [63:0] taylor_q48(input logic [63:0] k);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] div;
    term = 64'd1 << 48;
    pos  = term;
    neg  = '0;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      div  = 64'(DEPTH) * 64'(n);
      term = (term * k) / div;
      if (n % 2 == 1) neg += term;
      else pos += term;
    end
    return (pos >= neg) ? pos - neg : 64'd0;
  endfunction

  // Build both exponential tables once, before the first edge
  initial begin
    logic [63:0] e1;
    for (int k = 0; k <= DEPTH; k++) begin
      frac_lut[k] = 17'((taylor_q48(64'(k)) + (64'd1 << 31)) >> 32);
    end
    e1 = (taylor_q48(64'(DEPTH)) + (64'd1 << 16)) >> 17;
    whole_lut[0] = 64'd1 << 31;
    for (int k = 1; k < INT_LIMIT; k++) begin
      whole_lut[k] = (whole_lut[k-1] * e1 + (64'd1 << 30)) >> 31;
    end
  end

  // Expected result of one measurement: scale * density * exp(-echo / T2)
  function automatic out_t decay_value(input in_t it);
    out_t        r;
    logic [63:0] num;
    logic [63:0] ratio;
    logic [63:0] frac;
    logic [63:0] slot;
    logic [63:0] ex;
    logic [63:0] sc;
    logic [63:0] prod;
    logic [63:0] rnd;
    r.model_value = '0;
    r.zero_t2     = 1'b0;
    if (it.t2_time == '0) begin
      r.zero_t2 = 1'b1;
      return r;
    end
    num   = ({40'd0, it.echo_time} << 16) + {41'd0, it.t2_time[T2_W-1:1]};
    ratio = num / {40'd0, it.t2_time};
    // a ratio of 16.0 or more decays to nothing
    if (ratio >= (64'(INT_LIMIT) << 16)) begin
      ex = '0;
    end else begin
      frac = ratio & 64'hFFFF;
      slot = (frac * 64'(DEPTH) + 64'd32768) >> 16;
      if (slot > 64'(DEPTH)) slot = 64'(DEPTH);
      ex = (whole_lut[ratio[19:16]] * {47'd0, frac_lut[slot]} + (64'd1 << 30)) >> 31;
    end
    sc   = (it.volume_index == '0) ? {48'd0, UNIT_SCALE} : {48'd0, it.volume_scale};
    prod = {32'd0, it.proton_density} * ex * sc;
    rnd  = (prod + (64'd1 << 29)) >> ROUND_SHIFT;
    r.model_value = (rnd > 64'hFFFF_FFFF) ? '1 : rnd[VAL_W-1:0];
    return r;
  endfunction

  // Queue a prediction per input transfer, check each output transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      pending_values.delete();
      mismatches <= 0;
      awaited    <= 0;
    end else begin
      step_errs = 0;
      if (in_valid && !in_stall) pending_values.push_back(decay_value(in_data));
      if (out_valid && !out_stall) begin
        if (pending_values.size() == 0) begin
          $display("%0t: unexpected result, got value %h zero_t2 %b",
                   $time, out_data.model_value, out_data.zero_t2);
          step_errs++;
        end else begin
          want = pending_values.pop_front();
          if (out_data.model_value !== want.model_value) begin
            $display("%0t: model_value mismatch, expected %h, got %h",
                     $time, want.model_value, out_data.model_value);
            step_errs++;
          end
          if (out_data.zero_t2 !== want.zero_t2) begin
            $display("%0t: zero_t2 mismatch, expected %b, got %b",
                     $time, want.zero_t2, out_data.zero_t2);
            step_errs++;
          end
        end
      end
      mismatches <= mismatches + step_errs;
      awaited    <= pending_values.size();
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  import t2dm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1280;
  localparam int HOLD_CYCLES  = 200;
  localparam int BURST_START  = 300;
  localparam int HOLD_AT      = 320;
  localparam int BURST_END    = 450;
  localparam int DRAIN_AT     = 800;
  localparam int SETTLE       = 40;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  in_t  in_data;
  out_t out_data;
  int   mismatches;
  int   awaited;
  int   cycles;
  bit   stall_enable;
  bit   hold_off_req;

  t2_decay_model_eval u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  t2dm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up after a generous number of cycles
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t mk(input logic [DENS_W-1:0] dens, input logic [T2_W-1:0] t2,
                             input logic [ECHO_W-1:0] echo, input logic [VOL_W-1:0] vol,
                             input logic [SCALE_W-1:0] scale);
    in_t it;
    it.proton_density = dens;
    it.t2_time        = t2;
    it.echo_time      = echo;
    it.volume_index   = vol;
    it.volume_scale   = scale;
    return it;
  endfunction

  // Mostly ratios below 16 so the exponential path is exercised
  function automatic in_t random_item();
    in_t         it;
    logic [63:0] span;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) it.proton_density = 32'($urandom_range(0, 1000));
    else if (pick == 2) it.proton_density = '1;
    else it.proton_density = $urandom;
    pick = $urandom_range(0, 19);
    if (pick == 0) it.t2_time = '0;
    else if (pick < 5) it.t2_time = 24'($urandom_range(1, 255));
    else if (pick < 8) it.t2_time = 24'd65536;
    else it.t2_time = 24'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 7 && it.t2_time != '0) begin
      span = 64'(it.t2_time) * 64'($urandom_range(0, 16)) + 64'($urandom % it.t2_time);
      it.echo_time = (span > 64'hFF_FFFF) ? 24'($urandom) : span[ECHO_W-1:0];
    end else if (pick == 7) begin
      it.echo_time = '0;
    end else begin
      it.echo_time = 24'($urandom);
    end
    it.volume_index = ($urandom_range(0, 3) == 0) ? '0 : 8'($urandom);
    it.volume_scale = ($urandom_range(0, 5) == 0) ? UNIT_SCALE : 16'($urandom);
    return it;
  endfunction

  // Offer one item after an optional gap and hold it until the transfer
  task automatic send_item(input in_t it, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering until every predicted result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  // Result side: random stall stretches, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_enable && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_len() + 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (idle_len() + 1) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    stall_enable = 1'b1;
    hold_off_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero T2, alone and with every other field at its maximum
    send_item(mk(32'd1000, '0, 24'd100, '0, '0), idle_len());
    send_item(mk('1, '0, '1, '1, '1), idle_len());
    // zero echo: unit exponential, exact density, saturation, zero scale
    send_item(mk('1, 24'd1, '0, '0, '0), idle_len());
    send_item(mk('1, '1, '0, 8'd1, 16'hFFFF), idle_len());
    send_item(mk('1, 24'd100, '0, 8'd255, 16'h0000), idle_len());
    send_item(mk(32'd123456, 24'd500, '0, '0, 16'hFFFF), idle_len());
    send_item(mk('0, 24'd777, 24'd300, 8'd5, 16'h4000), idle_len());
    send_item(mk(32'd1, 24'd2, 24'd1, '0, '0), idle_len());
    // a T2 of 65536 puts the echo straight into the Q4.16 ratio
    send_item(mk('1, 24'd65536, 24'h0F_FFFF, '0, '0), idle_len());
    send_item(mk('1, 24'd65536, 24'h10_0000, '0, '0), idle_len());
    send_item(mk('1, 24'd65536, 24'h00_FFFF, '0, '0), idle_len());
    send_item(mk('1, 24'd65536, 24'h00_8000, '0, '0), idle_len());
    send_item(mk('1, 24'd65536, 24'h0A_0080, 8'd2, 16'h7FFF), idle_len());
    send_item(mk('1, 24'd65536, 24'h00_0001, 8'd1, 16'h4000), idle_len());
    // large ratio just either side of 16.0
    send_item(mk('1, 24'd1000, 24'd15999, '0, '0), idle_len());
    send_item(mk('1, 24'd1000, 24'd16000, '0, '0), idle_len());
    send_item(mk('1, 24'd1, '1, 8'd1, 16'h8000), idle_len());
    // widest T2 and echo
    send_item(mk('1, '1, '1, '0, '0), idle_len());
    send_item(mk('1, '1, 24'd1, '0, '0), idle_len());
    send_item(mk(32'h8000_0000, 24'd3, 24'd7, 8'h80, 16'hC000), idle_len());
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == BURST_START) stall_enable = 1'b0;
      if (n == HOLD_AT) hold_off_req = 1'b1;
      if (n == BURST_END) stall_enable = 1'b1;
      if (n == DRAIN_AT) wait_drained();
      send_item(random_item(), (n >= BURST_START && n < BURST_END) ? 0 : idle_len());
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
